>>> sv/assert_macros.svh
// Assertion macros for the RTL of the Q-learning agent.
// No dependencies; the including file supplies clock, reset and expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition c must hold in the same cycle as a.
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("implication check failed");

// Condition c must hold in the cycle after a.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle check failed");

`endif

>>> sv/tql_pkg.sv
// Package of the Q-learning agent: field widths, fixed-point constants,
// controller state type and the command/status structs. No dependencies.
package tql_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned IN_PT_W   = 5;
  localparam int unsigned DRAW_W    = 16;
  localparam int unsigned RATE_W    = 17;
  localparam int unsigned REWARD_W  = 20;
  localparam int unsigned OUT_Q_W   = 20;

  // Fixed-point constants: alpha = 410/4096, gamma = 3686/4096.
  localparam int unsigned FRAC_BITS = 12;
  localparam logic signed [10:0] ALPHA_S = 11'sd410;
  localparam logic signed [12:0] GAMMA_S = 13'sd3686;

  localparam logic [IN_PT_W-1:0] BUST_POINTS = 5'd21;
  localparam logic [RATE_W-1:0]  RATE_RESET  = 17'd6554;

  // Item kinds and actions.
  localparam logic KIND_DECIDE = 1'b0;
  localparam logic KIND_REWARD = 1'b1;
  localparam logic ACT_STAND   = 1'b0;
  localparam logic ACT_HIT     = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_RD_DEC,
    ST_CMP_DEC,
    ST_RD_CUR,
    ST_RD_N1,
    ST_RD_N0,
    ST_GMUL,
    ST_TD,
    ST_AMUL,
    ST_SUM,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    ADDR_STAND,
    ADDR_HIT,
    ADDR_LAST,
    ADDR_NEXT_HIT,
    ADDR_NEXT_STAND
  } rd_sel_e;

  typedef struct packed {
    logic    load_item;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    cap_a;
    logic    cap_cur;
    logic    max_en;
    logic    gmul_en;
    logic    td_en;
    logic    amul_en;
    logic    sum_en;
    logic    dec_quick;
    logic    dec_greedy;
    logic    clr_en;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic is_reward;
    logic early;
    logic explore;
    logic over;
    logic clr_last;
    logic out_free;
  } status_t;

endpackage

>>> sv/tql_in_if.sv
// Input channel of the Q-learning agent: valid/ready plus the item fields.
// Depends on tql_pkg for the field widths.
interface tql_in_if;
  import tql_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [IN_PT_W-1:0]         player_points;
  logic [IN_PT_W-1:0]         dealer_points;
  logic [IN_PT_W-1:0]         new_player_points;
  logic [DRAW_W-1:0]          random_draw;
  logic                       coin_flip;
  logic signed [REWARD_W-1:0] reward;
  logic                       game_over;

  modport source (
    output valid, kind, player_points, dealer_points, new_player_points,
           random_draw, coin_flip, reward, game_over,
    input  ready
  );

  modport sink (
    input  valid, kind, player_points, dealer_points, new_player_points,
           random_draw, coin_flip, reward, game_over,
    output ready
  );
endinterface

>>> sv/tql_out_if.sv
// Output channel of the Q-learning agent: valid/ready plus the result fields.
// Depends on tql_pkg for the field widths.
interface tql_out_if;
  import tql_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic                      explored;
  logic signed [OUT_Q_W-1:0] updated_q;
  logic                      q_written;

  modport source (
    output valid, hit, explored, updated_q, q_written,
    input  ready
  );

  modport sink (
    input  valid, hit, explored, updated_q, q_written,
    output ready
  );
endinterface

>>> sv/tql_ctrl.sv
// Controller state machine of the Q-learning agent.
// Depends on tql_pkg for the state type and the command/status structs.
module tql_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tql_pkg::status_t status_i,
  output tql_pkg::cmd_t    cmd_o
);
  import tql_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        if (status_i.is_reward) begin
          state_d = ST_RD_CUR;
        end else if (status_i.early || status_i.explore) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_RD_DEC;
        end
      end
      ST_RD_DEC:  state_d = ST_CMP_DEC;
      ST_CMP_DEC: state_d = ST_DONE;
      ST_RD_CUR: begin
        state_d = status_i.over ? ST_TD : ST_RD_N1;
      end
      ST_RD_N1: state_d = ST_RD_N0;
      ST_RD_N0: state_d = ST_GMUL;
      ST_GMUL:  state_d = ST_TD;
      ST_TD:    state_d = ST_AMUL;
      ST_AMUL:  state_d = ST_SUM;
      ST_SUM:   state_d = ST_DONE;
      ST_DONE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Command outputs to the datapath.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_en = 1'b1;
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      ST_LOOK: begin
        if (status_i.is_reward) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = ADDR_LAST;
        end else if (status_i.early || status_i.explore) begin
          cmd_o.dec_quick = 1'b1;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = ADDR_STAND;
        end
      end
      ST_RD_DEC: begin
        cmd_o.cap_a  = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ADDR_HIT;
      end
      ST_CMP_DEC: cmd_o.dec_greedy = 1'b1;
      ST_RD_CUR: begin
        cmd_o.cap_cur = 1'b1;
        if (!status_i.over) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = ADDR_NEXT_HIT;
        end
      end
      ST_RD_N1: begin
        cmd_o.cap_a  = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ADDR_NEXT_STAND;
      end
      ST_RD_N0: cmd_o.max_en   = 1'b1;
      ST_GMUL:  cmd_o.gmul_en  = 1'b1;
      ST_TD:    cmd_o.td_en    = 1'b1;
      ST_AMUL:  cmd_o.amul_en  = 1'b1;
      ST_SUM:   cmd_o.sum_en   = 1'b1;
      ST_DONE:  cmd_o.out_load = status_i.out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

>>> sv/tql_dp.sv
// Datapath of the Q-learning agent: Q table memory, item and state registers,
// update arithmetic and output register. Depends on tql_pkg and tql_out_if.
module tql_dp #(
  parameter int unsigned POINT_BITS = 5,
  parameter int unsigned Q_WIDTH    = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tql_pkg::cmd_t                       cmd_i,
  output tql_pkg::status_t                    status_o,
  input  logic                                cfg_we_i,
  input  logic [tql_pkg::RATE_W-1:0]          cfg_data_i,
  input  logic                                kind_i,
  input  logic [tql_pkg::IN_PT_W-1:0]         player_points_i,
  input  logic [tql_pkg::IN_PT_W-1:0]         dealer_points_i,
  input  logic [tql_pkg::IN_PT_W-1:0]         new_player_points_i,
  input  logic [tql_pkg::DRAW_W-1:0]          random_draw_i,
  input  logic                                coin_flip_i,
  input  logic signed [tql_pkg::REWARD_W-1:0] reward_i,
  input  logic                                game_over_i,
  tql_out_if.source                           out_o
);
  import tql_pkg::*;

  localparam int unsigned AW    = 2 * POINT_BITS + 1;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned TW    = ((Q_WIDTH > REWARD_W) ? Q_WIDTH : REWARD_W) + 2;
  localparam int unsigned GW    = Q_WIDTH + 13;
  localparam int unsigned MW    = TW + 10;

  // Item registers, loaded when a transaction is accepted.
  logic                       kind_q;
  logic [IN_PT_W-1:0]         player_q, dealer_q, newp_q;
  logic [DRAW_W-1:0]          draw_q;
  logic                       coin_q;
  logic signed [REWARD_W-1:0] reward_q;
  logic                       over_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q   <= kind_i;
      player_q <= player_points_i;
      dealer_q <= dealer_points_i;
      newp_q   <= new_player_points_i;
      draw_q   <= random_draw_i;
      coin_q   <= coin_flip_i;
      reward_q <= reward_i;
      over_q   <= game_over_i;
    end
  end

  // Exploration rate register and remembered state of the last decision.
  logic [RATE_W-1:0]     rate_q;
  logic [POINT_BITS-1:0] last_player_q, last_dealer_q;
  logic                  last_action_q;
  logic [AW-1:0]         clr_cnt_q;

  // Decision flags of the held item.
  logic early, explore;
  assign early   = (player_q >= BUST_POINTS);
  assign explore = ({1'b0, draw_q} < rate_q);

  // Table index fields, wrapped to the point width.
  logic [POINT_BITS-1:0] pp, dp, np;
  logic [AW-1:0]         last_idx, rd_addr;
  assign pp       = POINT_BITS'(player_q);
  assign dp       = POINT_BITS'(dealer_q);
  assign np       = POINT_BITS'(newp_q);
  assign last_idx = {last_player_q, last_dealer_q, last_action_q};

  // Read address decoder.
  always_comb begin
    unique case (cmd_i.rd_sel)
      ADDR_STAND:      rd_addr = {pp, dp, ACT_STAND};
      ADDR_HIT:        rd_addr = {pp, dp, ACT_HIT};
      ADDR_LAST:       rd_addr = last_idx;
      ADDR_NEXT_HIT:   rd_addr = {np, last_dealer_q, ACT_HIT};
      ADDR_NEXT_STAND: rd_addr = {np, last_dealer_q, ACT_STAND};
      default:         rd_addr = last_idx;
    endcase
  end

  // Arithmetic registers of the update.
  logic signed [Q_WIDTH-1:0] rd_data_q, q_a_q, q_cur_q, m_q;
  logic signed [GW-1:0]      gmul_q;
  logic signed [TW-1:0]      td_q;
  logic signed [MW-1:0]      amul_q;

  logic signed [Q_WIDTH-1:0] fut, fut_sel, nq;
  logic signed [TW-3:0]      d_val;
  logic signed [TW-1:0]      sum_v;
  logic [TW-Q_WIDTH:0]       sum_top;

  // Floor division by 4096 is an arithmetic shift.
  assign fut     = gmul_q[Q_WIDTH+FRAC_BITS-1:FRAC_BITS];
  assign fut_sel = over_q ? '0 : fut;
  assign d_val   = amul_q[MW-1:FRAC_BITS];
  assign sum_v   = TW'(q_cur_q) + TW'(d_val);
  assign sum_top = sum_v[TW-1:Q_WIDTH-1];

  // Saturate the new value to the Q range.
  always_comb begin
    if ((sum_top == '0) || (sum_top == '1)) begin
      nq = sum_v[Q_WIDTH-1:0];
    end else if (sum_v[TW-1]) begin
      nq = {1'b1, {(Q_WIDTH-1){1'b0}}};
    end else begin
      nq = {1'b0, {(Q_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_a)   q_a_q   <= rd_data_q;
    if (cmd_i.cap_cur) q_cur_q <= rd_data_q;
    if (cmd_i.max_en)  m_q     <= (q_a_q > rd_data_q) ? q_a_q : rd_data_q;
    if (cmd_i.gmul_en) gmul_q  <= GW'(m_q) * GW'(GAMMA_S);
    if (cmd_i.td_en)   td_q    <= TW'(reward_q) + TW'(fut_sel) - TW'(q_cur_q);
    if (cmd_i.amul_en) amul_q  <= MW'(td_q) * MW'(ALPHA_S);
  end

  // Q table memory: one write port, one registered read port.
  logic [Q_WIDTH-1:0] mem [DEPTH];
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [Q_WIDTH-1:0] mem_wdata;

  assign mem_we    = cmd_i.clr_en || cmd_i.sum_en;
  assign mem_waddr = cmd_i.clr_en ? clr_cnt_q : last_idx;
  assign mem_wdata = cmd_i.clr_en ? '0 : nq;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i.rd_en) rd_data_q <= mem[rd_addr];
  end

  // Result registers of the current item.
  logic                      res_hit_q, res_expl_q, res_wr_q;
  logic signed [OUT_Q_W-1:0] res_q_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.dec_quick) begin
      res_hit_q  <= early ? ACT_STAND : coin_q;
      res_expl_q <= !early;
      res_q_q    <= '0;
      res_wr_q   <= 1'b0;
    end else if (cmd_i.dec_greedy) begin
      res_hit_q  <= (rd_data_q > q_a_q) ? ACT_HIT : ACT_STAND;
      res_expl_q <= 1'b0;
      res_q_q    <= '0;
      res_wr_q   <= 1'b0;
    end else if (cmd_i.sum_en) begin
      res_hit_q  <= 1'b0;
      res_expl_q <= 1'b0;
      res_q_q    <= OUT_Q_W'(nq);
      res_wr_q   <= 1'b1;
    end
  end

  // Control registers: rate, remembered decision, clear counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q        <= RATE_RESET;
      last_player_q <= '0;
      last_dealer_q <= '0;
      last_action_q <= ACT_STAND;
      clr_cnt_q     <= '0;
    end else begin
      if (cfg_we_i) rate_q <= cfg_data_i;
      if (cmd_i.clr_en) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_i.dec_quick && !early) begin
        last_player_q <= pp;
        last_dealer_q <= dp;
        last_action_q <= coin_q;
      end else if (cmd_i.dec_greedy) begin
        last_player_q <= pp;
        last_dealer_q <= dp;
        last_action_q <= (rd_data_q > q_a_q) ? ACT_HIT : ACT_STAND;
      end
    end
  end

  // Output register: holds a result until the sink takes it.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  logic                      out_hit_q, out_expl_q, out_wr_q;
  logic signed [OUT_Q_W-1:0] out_q_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_hit_q  <= res_hit_q;
      out_expl_q <= res_expl_q;
      out_q_q    <= res_q_q;
      out_wr_q   <= res_wr_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.hit       = out_hit_q;
  assign out_o.explored  = out_expl_q;
  assign out_o.updated_q = out_q_q;
  assign out_o.q_written = out_wr_q;

  // Status back to the controller.
  assign status_o.is_reward = (kind_q == KIND_REWARD);
  assign status_o.early     = early;
  assign status_o.explore   = explore;
  assign status_o.over      = over_q;
  assign status_o.clr_last  = (clr_cnt_q == '1);
  assign status_o.out_free  = !out_valid_q || out_o.ready;

endmodule

>>> sv/tabular_q_learning_agent.sv
// Epsilon-greedy Q-learning agent, one item at a time through a Q table with one read port.
// The time per item depends on its kind: an early stand or exploration, a greedy decision,
// or a reward, shorter with game_over; it is set by the table's one read port and the two
// registered constant multiplies. The result is registered and shown when the controller
// returns to idle, and a result the sink holds back stalls the input.
// After reset the table is cleared, one entry a cycle, over all 2^(2*POINT_BITS+1) entries.
`include "assert_macros.svh"

module tabular_q_learning_agent #(
  parameter int unsigned POINT_BITS = 5,
  parameter int unsigned Q_WIDTH    = 20
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tql_pkg::RATE_W-1:0] cfg_data_i,
  tql_in_if.sink                     in_i,
  tql_out_if.source                  out_o
);
  import tql_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_i.ready = in_ready;

  // Controller.
  tql_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath.
  tql_dp #(
    .POINT_BITS (POINT_BITS),
    .Q_WIDTH    (Q_WIDTH)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .cfg_we_i            (cfg_we_i),
    .cfg_data_i          (cfg_data_i),
    .kind_i              (in_i.kind),
    .player_points_i     (in_i.player_points),
    .dealer_points_i     (in_i.dealer_points),
    .new_player_points_i (in_i.new_player_points),
    .random_draw_i       (in_i.random_draw),
    .coin_flip_i         (in_i.coin_flip),
    .reward_i            (in_i.reward),
    .game_over_i         (in_i.game_over),
    .out_o               (out_o)
  );

  // A transaction is taken only once; the block is busy the cycle after.
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready)
  // A result is loaded only into a free output register.
  `ASSERT_IMPLIES(a_no_overwrite, clk_i, rst_ni, cmd.out_load, !out_o.valid || out_o.ready)
  // A loaded result is presented in the next cycle.
  `ASSERT_NEXT(a_load_shows, clk_i, rst_ni, cmd.out_load, out_o.valid)
  // Clearing excludes update writes and input transactions.
  `ASSERT_IMPLIES(a_clear_alone, clk_i, rst_ni, cmd.clr_en, !cmd.sum_en && !in_i.ready)

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the Q-learning agent: directed table, then random episodes.
// Depends on tql_pkg, tql_in_if, tql_out_if and tabular_q_learning_agent.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tql_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 246;
  localparam int NUM_PHASES   = 6;
  localparam int LONG_HOLD    = 400;

  // One input transaction and one output transaction, at the block's widths.
  typedef struct packed {
    logic                       kind;
    logic [IN_PT_W-1:0]         player;
    logic [IN_PT_W-1:0]         dealer;
    logic [IN_PT_W-1:0]         next_player;
    logic [DRAW_W-1:0]          draw;
    logic                       coin;
    logic signed [REWARD_W-1:0] reward;
    logic                       over;
  } agent_item_t;

  typedef struct packed {
    logic                      hit;
    logic                      explored;
    logic signed [OUT_Q_W-1:0] q;
    logic                      written;
  } agent_result_t;

  typedef enum logic {ROW_ITEM, ROW_RATE} row_op_e;

  typedef struct {
    row_op_e       op;
    agent_item_t   item;
    logic [RATE_W-1:0] rate;
    bit            typed;
    agent_result_t want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [RATE_W-1:0] cfg_data_i;

  tql_in_if  in_if ();
  tql_out_if out_if ();

  tabular_q_learning_agent uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Shadow copy of the agent: Q table, remembered decision and explore rate.
  logic signed [OUT_Q_W-1:0] q_shadow [2048];
  logic [IN_PT_W-1:0] mem_player;
  logic [IN_PT_W-1:0] mem_dealer;
  logic               mem_action;
  logic [RATE_W-1:0]  explore_rate;

  agent_result_t pending_results [$];
  int mismatches;
  int send_idle_pct;
  int recv_idle_pct;
  int phase_no;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Logs one mismatch line and counts it.
  task automatic flag_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("%0t ns: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  // Computes the result of one transaction and advances the shadow state.
  function automatic agent_result_t predict_outcome(input agent_item_t it);
    agent_result_t res;
    logic [10:0]   cur_idx;
    longint        q_cur;
    longint        q_hit;
    longint        q_stand;
    longint        future;
    longint        new_q;
    res = '0;
    if (it.kind == KIND_DECIDE) begin
      // Hands at twenty-one or more stand without touching the memory.
      if (it.player >= BUST_POINTS) begin
        return res;
      end
      if ({1'b0, it.draw} < explore_rate) begin
        res.hit      = it.coin;
        res.explored = 1'b1;
      end else begin
        // Greedy choice; a tie goes to stand.
        res.hit = (q_shadow[{it.player, it.dealer, ACT_HIT}] >
                   q_shadow[{it.player, it.dealer, ACT_STAND}]) ? ACT_HIT : ACT_STAND;
      end
      mem_player = it.player;
      mem_dealer = it.dealer;
      mem_action = res.hit;
    end else begin
      cur_idx = {mem_player, mem_dealer, mem_action};
      q_cur   = q_shadow[cur_idx];
      future  = 0;
      if (!it.over) begin
        q_hit   = q_shadow[{it.next_player, mem_dealer, ACT_HIT}];
        q_stand = q_shadow[{it.next_player, mem_dealer, ACT_STAND}];
        future  = ((q_hit > q_stand ? q_hit : q_stand) * GAMMA_S) >>> FRAC_BITS;
      end
      new_q = q_cur + (((longint'($signed(it.reward)) + future - q_cur) * ALPHA_S) >>> FRAC_BITS);
      // Saturate to the Q range.
      if (new_q > 524287) begin
        new_q = 524287;
      end else if (new_q < -524288) begin
        new_q = -524288;
      end
      q_shadow[cur_idx] = new_q[OUT_Q_W-1:0];
      res.q       = new_q[OUT_Q_W-1:0];
      res.written = 1'b1;
    end
    return res;
  endfunction

  // Offers one transaction after a random gap and queues its expected result.
  task automatic push_item(input agent_item_t it, input bit typed, input agent_result_t want);
    int gap;
    agent_result_t pred;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid             <= 1'b1;
    in_if.kind              <= it.kind;
    in_if.player_points     <= it.player;
    in_if.dealer_points     <= it.dealer;
    in_if.new_player_points <= it.next_player;
    in_if.random_draw       <= it.draw;
    in_if.coin_flip         <= it.coin;
    in_if.reward            <= it.reward;
    in_if.game_over         <= it.over;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    pred = predict_outcome(it);
    pending_results.push_back(typed ? want : pred);
  endtask

  // Writes the explore rate once every pending result has come back.
  task automatic write_explore_rate(input logic [RATE_W-1:0] rate);
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= rate;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    explore_rate = rate;
  endtask

  function automatic stim_row_t decide_row(input int pl, input int dl, input int drw,
      input logic coin, input bit typed = 1'b0, input logic want_hit = ACT_STAND,
      input bit want_expl = 1'b0);
    stim_row_t row;
    row = '{op: ROW_ITEM, item: '0, rate: '0, typed: typed, want: '0};
    row.item.kind   = KIND_DECIDE;
    row.item.player = IN_PT_W'(pl);
    row.item.dealer = IN_PT_W'(dl);
    row.item.draw   = DRAW_W'(drw);
    row.item.coin   = coin;
    row.want.hit      = want_hit;
    row.want.explored = want_expl;
    return row;
  endfunction

  function automatic stim_row_t reward_row(input int np, input int rw, input logic over,
      input bit typed = 1'b0, input int want_q = 0);
    stim_row_t row;
    row = '{op: ROW_ITEM, item: '0, rate: '0, typed: typed, want: '0};
    row.item.kind        = KIND_REWARD;
    row.item.next_player = IN_PT_W'(np);
    row.item.reward      = REWARD_W'(rw);
    row.item.over        = over;
    row.want.q       = OUT_Q_W'(want_q);
    row.want.written = 1'b1;
    return row;
  endfunction

  function automatic stim_row_t rate_row(input int r);
    stim_row_t row;
    row = '{op: ROW_RATE, item: '0, rate: RATE_W'(r), typed: 1'b0, want: '0};
    return row;
  endfunction

  // Output side: checks each transaction and applies backpressure.
  initial begin
    int hold_left;
    bit hold_done;
    agent_result_t want;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("result with nothing pending", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_if.hit !== want.hit) begin
            flag_mismatch("hit", longint'(out_if.hit), longint'(want.hit));
          end
          if (out_if.explored !== want.explored) begin
            flag_mismatch("explored", longint'(out_if.explored), longint'(want.explored));
          end
          if (out_if.updated_q !== want.q) begin
            flag_mismatch("updated_q", longint'(out_if.updated_q), longint'(want.q));
          end
          if (out_if.q_written !== want.written) begin
            flag_mismatch("q_written", longint'(out_if.q_written), longint'(want.written));
          end
        end
      end
      // One long hold-off so the block backs up and stalls its input.
      if (!hold_done && phase_no == 1) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Run time limit.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tabular_q_learning_agent: mismatch");
    $finish;
  end

  // Stimulus: reset, directed table, then random phases.
  initial begin
    stim_row_t   rows [$];
    stim_row_t   row;
    agent_item_t it;
    int          items_done;
    int          pick;
    int          streak_len;
    int          pl;
    int          dl;
    bit          push_up;
    logic [RATE_W-1:0] rate;

    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_data_i              = '0;
    in_if.valid             = 1'b0;
    in_if.kind              = KIND_DECIDE;
    in_if.player_points     = '0;
    in_if.dealer_points     = '0;
    in_if.new_player_points = '0;
    in_if.random_draw       = '0;
    in_if.coin_flip         = 1'b0;
    in_if.reward            = '0;
    in_if.game_over         = 1'b0;
    foreach (q_shadow[i]) q_shadow[i] = '0;
    mem_player    = '0;
    mem_dealer    = '0;
    mem_action    = ACT_STAND;
    explore_rate  = RATE_RESET;
    mismatches    = 0;
    phase_no      = -1;
    send_idle_pct = 13;
    recv_idle_pct = 71;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, starting from the reset explore rate.
    rows.push_back(reward_row(0, -524288, 1'b1, 1'b1, -52480));  // reward before any decision
    rows.push_back(decide_row(21, 10, 0, ACT_HIT, 1'b1, ACT_STAND, 1'b0));
    rows.push_back(decide_row(31, 31, 65535, ACT_HIT, 1'b1, ACT_STAND, 1'b0));
    rows.push_back(decide_row(0, 0, 65535, ACT_STAND));
    rows.push_back(decide_row(20, 31, 65535, ACT_STAND, 1'b1, ACT_STAND, 1'b0));  // tie
    rows.push_back(decide_row(20, 31, 0, ACT_HIT, 1'b1, ACT_HIT, 1'b1));
    rows.push_back(reward_row(31, 524287, 1'b0));
    rows.push_back(reward_row(20, 0, 1'b0));
    rows.push_back(decide_row(20, 31, 6554, ACT_STAND));   // draw equal to the rate
    rows.push_back(decide_row(5, 2, 6553, ACT_STAND, 1'b1, ACT_STAND, 1'b1));
    rows.push_back(reward_row(0, -1, 1'b1));
    rows.push_back(rate_row(65536));                       // full exploration
    rows.push_back(decide_row(0, 0, 65535, ACT_STAND, 1'b1, ACT_STAND, 1'b1));
    rows.push_back(decide_row(19, 17, 65535, ACT_HIT, 1'b1, ACT_HIT, 1'b1));
    rows.push_back(decide_row(21, 0, 0, ACT_HIT, 1'b1, ACT_STAND, 1'b0));
    rows.push_back(reward_row(31, 524287, 1'b1));
    rows.push_back(rate_row(0));
    rows.push_back(decide_row(0, 0, 0, ACT_HIT));
    rows.push_back(decide_row(10, 21, 0, ACT_HIT, 1'b1, ACT_STAND, 1'b0));
    rows.push_back(reward_row(10, 4096, 1'b0));
    rows.push_back(reward_row(10, -524288, 1'b0));
    rows.push_back(decide_row(1, 1, 65535, ACT_HIT, 1'b1, ACT_STAND, 1'b0));
    rows.push_back(rate_row(65535));
    rows.push_back(decide_row(2, 3, 65535, ACT_HIT, 1'b1, ACT_STAND, 1'b0));
    rows.push_back(decide_row(2, 3, 65534, ACT_HIT, 1'b1, ACT_HIT, 1'b1));
    rows.push_back(reward_row(2, 2048, 1'b0));

    foreach (rows[i]) begin
      row = rows[i];
      if (row.op == ROW_RATE) begin
        write_explore_rate(row.rate);
      end else begin
        push_item(row.item, row.typed, row.want);
      end
    end

    // Random phases: each sets a rate and an idling pattern.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: rate = RATE_RESET;
        1: rate = 17'd0;
        2: rate = 17'd65536;
        3: rate = 17'd32768;
        4: rate = RATE_W'($urandom_range(1, 65534));
        default: rate = 17'd65535;
      endcase
      write_explore_rate(rate);
      phase_no = ph;
      case (ph / 2)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      items_done = 0;
      while (items_done < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          // Episode: a few decisions, then a reward for the last one.
          repeat ($urandom_range(1, 3)) begin
            it      = '0;
            it.kind = KIND_DECIDE;
            case ($urandom_range(19))
              0, 1:    it.player = IN_PT_W'($urandom_range(21, 31));
              2:       it.player = IN_PT_W'($urandom_range(0, 3));
              default: it.player = IN_PT_W'($urandom_range(4, 20));
            endcase
            it.dealer = IN_PT_W'(($urandom_range(4) == 0) ? $urandom_range(0, 31)
                                                          : $urandom_range(2, 11));
            it.draw   = DRAW_W'($urandom);
            it.coin   = 1'($urandom);
            push_item(it, 1'b0, '0);
            items_done++;
          end
          it             = '0;
          it.kind        = KIND_REWARD;
          it.next_player = IN_PT_W'(($urandom_range(3) == 0) ? $urandom_range(0, 31)
                                    : ((mem_player + $urandom_range(0, 10)) % 32));
          case ($urandom_range(9))
            0, 1, 2: it.reward = REWARD_W'($urandom);
            3, 4, 5: it.reward = REWARD_W'($urandom_range(0, 8192) - 4096);
            default: it.reward = REWARD_W'((($urandom_range(3)) - 1) * 4096);
          endcase
          it.over = 1'($urandom);
          it.draw = DRAW_W'($urandom);
          it.coin = 1'($urandom);
          push_item(it, 1'b0, '0);
          items_done++;
        end else if (pick < 85) begin
          // Long runs of large rewards on both actions of one state drive Q to saturation.
          pl         = $urandom_range(0, 20);
          dl         = $urandom_range(0, 31);
          push_up    = 1'($urandom);
          streak_len = $urandom_range(15, 30);
          for (int act = 0; act < 2; act++) begin
            it        = '0;
            it.kind   = KIND_DECIDE;
            it.player = IN_PT_W'(pl);
            it.dealer = IN_PT_W'(dl);
            it.coin   = act ? ACT_HIT : ACT_STAND;
            push_item(it, 1'b0, '0);
            items_done++;
            repeat (streak_len) begin
              it             = '0;
              it.kind        = KIND_REWARD;
              it.next_player = mem_player;
              it.reward      = REWARD_W'(push_up ? 524287 - $urandom_range(0, 4095)
                                                 : -524288 + $urandom_range(0, 4095));
              push_item(it, 1'b0, '0);
              items_done++;
            end
          end
        end else begin
          // Unstructured transaction with every field random.
          it             = '0;
          it.kind        = 1'($urandom);
          it.player      = IN_PT_W'($urandom);
          it.dealer      = IN_PT_W'($urandom);
          it.next_player = IN_PT_W'($urandom);
          it.draw        = DRAW_W'($urandom);
          it.coin        = 1'($urandom);
          it.reward      = REWARD_W'($urandom);
          it.over        = 1'($urandom);
          push_item(it, 1'b0, '0);
          items_done++;
        end
      end
    end

    // Drain the remaining results, then allow for stray outputs.
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tabular_q_learning_agent: match");
    end else begin
      $display("tabular_q_learning_agent: mismatch");
    end
    $finish;
  end

endmodule
